>>> hdl/etbv_pkg.sv
// etbv_pkg: types, constants and helper functions for the euler to basis vectors unit
// no dependencies
package etbv_pkg;

    localparam int OUT_FRAC_BITS   = 14;
    localparam int TRIG_ITERATIONS = 16;
    localparam int NUM_STEPS       = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
    localparam int FRAC            = 30;
    localparam int DEG_CIRCLE      = 23040;
    localparam int CW              = 34;   // cordic datapath width (Q2.30 plus headroom)
    localparam int PW              = 36;   // product / sum width
    // phase stages, one per cordic iteration, then map, products, sums and rounding
    localparam int LATENCY         = 2 + NUM_STEPS + 4;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] pitch_deg;
        logic signed [15:0] yaw_deg;
        logic signed [15:0] roll_deg;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } basis_t;

    // one cordic lane: vector, residual angle, quadrant
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
    } cordic_lane_t;

    function automatic logic signed [CW-1:0] atan_step(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return signed'({{(CW-32){1'b0}}, v});
    endfunction

    // floor(a*b / 2^30), Q2.30 by Q2.30
    function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b);
        logic signed [2*PW-1:0] p;
        p = a * b;
        return p[FRAC +: PW];
    endfunction

    // round half up to OUT_FRAC_BITS, saturate to +-1
    function automatic logic signed [15:0] to_out(input logic signed [PW-1:0] v);
        localparam int SH = FRAC - OUT_FRAC_BITS;
        logic signed [PW-1:0] r;
        logic signed [PW-1:0] lim;
        r = (v + (PW'(1) <<< (SH - 1))) >>> SH;
        lim = PW'(1) <<< OUT_FRAC_BITS;
        if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

endpackage

>>> hdl/euler_to_basis_vectors_unit.sv
// euler_to_basis_vectors_unit: phase, cordic and combine stages in one pipeline
// throughput one request per cycle unless the output stalls; the cordic chain has one register stage per iteration
// the whole pipeline advances together and holds when the output is stalled
// rst_n clears the valid bits only; data registers are not reset
// depends on etbv_pkg, etbv_phase, etbv_cordic_stage, etbv_combine
module euler_to_basis_vectors_unit
    import etbv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  angles_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output basis_t  out_data
);

    localparam int DEPTH = LATENCY;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             en;
    logic [31:0]      ph_p, ph_y, ph_r;
    cordic_lane_t     lane [3][NUM_STEPS+1];

    // stall only when the last stage holds an untaken result
    assign en       = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready = en;

    always_comb
    begin
        valid_next = {valid_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    etbv_phase u_ph_p (.clk(clk), .en(en), .angle(in_data.pitch_deg), .phase(ph_p));
    etbv_phase u_ph_y (.clk(clk), .en(en), .angle(in_data.yaw_deg),   .phase(ph_y));
    etbv_phase u_ph_r (.clk(clk), .en(en), .angle(in_data.roll_deg),  .phase(ph_r));

    always_comb
    begin
        lane[0][0] = '{x: CORDIC_GAIN, y: '0, z: CW'(ph_p[29:0]), quad: ph_p[31:30]};
        lane[1][0] = '{x: CORDIC_GAIN, y: '0, z: CW'(ph_y[29:0]), quad: ph_y[31:30]};
        lane[2][0] = '{x: CORDIC_GAIN, y: '0, z: CW'(ph_r[29:0]), quad: ph_r[31:30]};
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        for (genvar i = 0; i < NUM_STEPS; i++)
        begin : g_step
            etbv_cordic_stage u_stage (
                .clk(clk), .en(en), .step(5'(i)),
                .lane_in(lane[a][i]), .lane_out(lane[a][i+1])
            );
        end
    end

    etbv_combine u_comb (
        .clk(clk), .en(en),
        .lane_p(lane[0][NUM_STEPS]), .lane_y(lane[1][NUM_STEPS]),
        .lane_r(lane[2][NUM_STEPS]), .result(out_data)
    );

    assign out_valid = valid_reg[DEPTH-1];

endmodule

>>> hdl/etbv_phase.sv
// etbv_phase: reduces one Q10.6 angle mod 360 degrees and converts it to a 32-bit phase
// depends on etbv_pkg
module etbv_phase
    import etbv_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic [31:0]        phase
);

    // a*2^32/23040 = a*2^23/45; floor by reciprocal multiply, corrected once
    localparam logic [31:0] RECIP = 32'd3054198966; // floor(2^37/45)

    logic signed [16:0] red_a;
    logic [14:0]        red_reg;
    logic [14:0]        red_next;
    logic [46:0]        prod;
    logic [37:0]        num;
    logic [31:0]        q;
    logic [37:0]        rem;
    logic [31:0]        phase_reg;

    always_comb
    begin
        // angle range is +-512 degrees, so one or two corrections suffice
        red_a = 17'(angle);
        if (red_a >= 17'sd23040)
            red_a = red_a - 17'sd23040;
        if (red_a < 0)
            red_a = red_a + 17'sd23040;
        if (red_a < 0)
            red_a = red_a + 17'sd23040;
        red_next = red_a[14:0];
    end

    always_comb
    begin
        num  = {red_reg, 23'd0};
        prod = 47'(red_reg) * 47'(RECIP);
        q    = 32'(prod >> 14);
        rem  = num - 38'(q) * 38'd45;
        if (rem >= 38'd45)
            q = q + 32'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            phase_reg <= q;
        end
    end

    assign phase = phase_reg;

endmodule

>>> hdl/etbv_cordic_stage.sv
// etbv_cordic_stage: one registered rotation-mode cordic iteration for one lane
// depends on etbv_pkg
module etbv_cordic_stage
    import etbv_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  logic [4:0]   step,
    input  cordic_lane_t lane_in,
    output cordic_lane_t lane_out
);

    cordic_lane_t lane_reg;
    cordic_lane_t lane_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = lane_in.x >>> step;
        dy = lane_in.y >>> step;
        lane_next.quad = lane_in.quad;
        if (!lane_in.z[CW-1])
        begin
            lane_next.x = lane_in.x - dy;
            lane_next.y = lane_in.y + dx;
            lane_next.z = lane_in.z - atan_step(step);
        end
        else
        begin
            lane_next.x = lane_in.x + dy;
            lane_next.y = lane_in.y - dx;
            lane_next.z = lane_in.z + atan_step(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

>>> hdl/etbv_combine.sv
// etbv_combine: registered quadrant mapping, first products, second products and sums, then output rounding
// depends on etbv_pkg
module etbv_combine
    import etbv_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  cordic_lane_t lane_p,
    input  cordic_lane_t lane_y,
    input  cordic_lane_t lane_r,
    output basis_t       result
);

    logic signed [PW-1:0] cp_n, sp_n, cy_n, sy_n, cr_n, sr_n;
    logic signed [PW-1:0] cp_reg, sp_reg, cy_reg, sy_reg, cr_reg, sr_reg;
    // stage b: first products
    logic signed [PW-1:0] spsy_reg, spcy_reg, cpsy_reg, cpcy_reg, cycr_reg, cpsr_reg;
    logic signed [PW-1:0] sycr_reg, cysr_reg, cpcr_reg, sysr_reg;
    logic signed [PW-1:0] sp2_reg, cr2_reg, sr2_reg;
    // stage c: second products and sums
    logic signed [PW-1:0] v_reg [9];
    basis_t               result_reg;

    function automatic void map_quad(input cordic_lane_t l,
                                     output logic signed [PW-1:0] c,
                                     output logic signed [PW-1:0] s);
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        x = PW'(l.x);
        y = PW'(l.y);
        case (l.quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    always_comb
    begin
        map_quad(lane_p, cp_n, sp_n);
        map_quad(lane_y, cy_n, sy_n);
        map_quad(lane_r, cr_n, sr_n);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg <= cp_n; sp_reg <= sp_n;
            cy_reg <= cy_n; sy_reg <= sy_n;
            cr_reg <= cr_n; sr_reg <= sr_n;

            spsy_reg <= mulq(sp_reg, sy_reg);
            spcy_reg <= mulq(sp_reg, cy_reg);
            cpsy_reg <= mulq(cp_reg, sy_reg);
            cpcy_reg <= mulq(cp_reg, cy_reg);
            cycr_reg <= mulq(cy_reg, cr_reg);
            cpsr_reg <= mulq(cp_reg, sr_reg);
            sycr_reg <= mulq(sy_reg, cr_reg);
            cysr_reg <= mulq(cy_reg, sr_reg);
            cpcr_reg <= mulq(cp_reg, cr_reg);
            sysr_reg <= mulq(sy_reg, sr_reg);
            sp2_reg  <= sp_reg;
            cr2_reg  <= cr_reg;
            sr2_reg  <= sr_reg;

            v_reg[0] <= cpsy_reg;
            v_reg[1] <= sp2_reg;
            v_reg[2] <= cpcy_reg;
            v_reg[3] <= cycr_reg - mulq(spsy_reg, sr2_reg);
            v_reg[4] <= cpsr_reg;
            v_reg[5] <= -sycr_reg - mulq(spcy_reg, sr2_reg);
            v_reg[6] <= -mulq(spsy_reg, cr2_reg) - cysr_reg;
            v_reg[7] <= cpcr_reg;
            v_reg[8] <= -mulq(spcy_reg, cr2_reg) + sysr_reg;

            result_reg.fwd_x   <= to_out(v_reg[0]);
            result_reg.fwd_y   <= to_out(v_reg[1]);
            result_reg.fwd_z   <= to_out(v_reg[2]);
            result_reg.right_x <= to_out(v_reg[3]);
            result_reg.right_y <= to_out(v_reg[4]);
            result_reg.right_z <= to_out(v_reg[5]);
            result_reg.up_x    <= to_out(v_reg[6]);
            result_reg.up_y    <= to_out(v_reg[7]);
            result_reg.up_z    <= to_out(v_reg[8]);
        end
    end

    assign result = result_reg;

endmodule

>>> hdl/etbv_checker.sv
// etbv_checker: port-level checks for euler_to_basis_vectors_unit
// depends on etbv_pkg; bound to the top level below
module etbv_checker
    import etbv_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input basis_t  out_data
);

    localparam logic signed [15:0] LIM = 16'sd16384;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.fwd_y <= LIM && out_data.fwd_y >= -LIM
                   && out_data.up_z <= LIM && out_data.up_z >= -LIM)
        else $error("component out of range");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind euler_to_basis_vectors_unit etbv_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for euler_to_basis_vectors_unit
// depends on etbv_pkg and the unit; predicts each basis from its own cordic model
module tb
    import etbv_pkg::*;
();

    localparam int MAX_CYCLE = 400000;

    logic    clk;
    logic    rst_n;
    logic    in_valid = 1'b0;
    logic    in_ready;
    angles_t in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    basis_t  out_data;

    angles_t angle_queue[$];
    basis_t  basis_queue[$];
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_errors = 0;
    int      cycle = 0;
    bit      calm;
    bit      hold_long;
    bit      in_fire = 1'b0;

    euler_to_basis_vectors_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return shr_floor(a * b, 30);
    endfunction

    function automatic longint atan_phase(int i);
        longint steps[32] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
            'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
            'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
            'h00000001, 'h00000000};
        return steps[i];
    endfunction

    function automatic void angle_sincos(input logic signed [15:0] deg,
                                         output longint c, output longint s);
        longint  a;
        longint  phase;
        longint  x;
        longint  y;
        longint  z;
        longint  dx;
        longint  dy;
        int      quad;
        a = longint'(deg) % DEG_CIRCLE;
        if (a < 0)
            a += DEG_CIRCLE;
        phase = (a << 32) / DEG_CIRCLE;
        quad = int'((phase >> 30) & 3);
        z = phase & 'h3FFFFFFF;
        x = 652032874;
        y = 0;
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            dx = shr_floor(x, i);
            dy = shr_floor(y, i);
            if (z >= 0)
            begin
                x -= dy; y += dx; z -= atan_phase(i);
            end
            else
            begin
                x += dy; y -= dx; z += atan_phase(i);
            end
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [15:0] to_q14(longint v);
        longint lim;
        int     sh;
        sh = 30 - OUT_FRAC_BITS;
        lim = longint'(1) << OUT_FRAC_BITS;
        v = shr_floor(v + (longint'(1) << (sh - 1)), sh);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[15:0];
    endfunction

    function automatic basis_t predict_basis(angles_t ang);
        longint cp, sp, cy, sy, cr, sr, spsy, spcy;
        basis_t b;
        angle_sincos(ang.pitch_deg, cp, sp);
        angle_sincos(ang.yaw_deg, cy, sy);
        angle_sincos(ang.roll_deg, cr, sr);
        spsy = qmul(sp, sy);
        spcy = qmul(sp, cy);
        b.fwd_x   = to_q14(qmul(cp, sy));
        b.fwd_y   = to_q14(sp);
        b.fwd_z   = to_q14(qmul(cp, cy));
        b.right_x = to_q14(qmul(cy, cr) - qmul(spsy, sr));
        b.right_y = to_q14(qmul(cp, sr));
        b.right_z = to_q14(-qmul(sy, cr) - qmul(spcy, sr));
        b.up_x    = to_q14(-qmul(spsy, cr) - qmul(cy, sr));
        b.up_y    = to_q14(qmul(cp, cr));
        b.up_z    = to_q14(-qmul(spcy, cr) + qmul(sy, sr));
        return b;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 23040 * 2) - 23040);
            1: return 16'(($urandom_range(0, 8) - 4) * 5760);
            2: return 16'(($urandom_range(0, 8) - 4) * 5760 + $urandom_range(0, 4) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_request(input logic signed [15:0] p, input logic signed [15:0] y,
                               input logic signed [15:0] r);
        angles_t a;
        a.pitch_deg = p;
        a.yaw_deg   = y;
        a.roll_deg  = r;
        angle_queue.push_back(a);
    endtask

    // driver
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
                n_sent <= n_sent + 1;
            if (!in_valid || in_fire)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (angle_queue.size() > 0)
                begin
                    in_data  <= angle_queue.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 16);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // accepted requests enter the prediction queue at the rising edge
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
            basis_queue.push_back(predict_basis(in_data));
    end

    // receiver stalls
    int recv_gap = 0;
    int hold_count = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_long)
            begin
                out_ready <= 1'b0;
                hold_count <= hold_count + 1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    recv_gap <= $urandom_range(1, 16);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        basis_t exp_b;
        if (rst_n && out_valid && out_ready)
        begin
            if (basis_queue.size() == 0)
            begin
                $display("%0t: result with no request pending: %h", $time, out_data);
                n_errors++;
            end
            else
            begin
                exp_b = basis_queue.pop_front();
                if (exp_b !== out_data)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_b, out_data);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int tail;
        rst_n = 1'b0;
        calm = 1'b0; hold_long = 1'b0;

        // directed: extremes, quadrant edges, negatives, wrap past 360
        add_request(16'sh0000, 16'sh0000, 16'sh0000);
        add_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        add_request(-16'sd32768, -16'sd32768, -16'sd32768);
        add_request(16'sd5760, 16'sd0, 16'sd0);
        add_request(16'sd0, 16'sd5760, 16'sd0);
        add_request(16'sd0, 16'sd0, 16'sd5760);
        add_request(16'sd11520, 16'sd17280, 16'sd23039);
        add_request(-16'sd5760, -16'sd11520, -16'sd17280);
        add_request(16'sd23040, -16'sd23040, 16'sd23041);
        add_request(-16'sd1, 16'sd1, 16'sh5555);
        add_request(16'shAAAA, 16'sh5555, 16'shAAAA);
        add_request(16'sd2880, 16'sd2880, 16'sd2880);
        add_request(16'sd5759, 16'sd5761, 16'sd17279);
        for (int i = 0; i < 60; i++)
            add_request(rand_angle(), rand_angle(), rand_angle());

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // long receiver hold while the sender keeps offering
        hold_long = 1'b1;
        wait (hold_count >= 3 * LATENCY);
        hold_long = 1'b0;

        for (int i = 0; i < 380; i++)
            add_request(rand_angle(), rand_angle(), rand_angle());
        while (angle_queue.size() != 0)
            @(posedge clk);
        calm = 1'b1;
        for (int i = 0; i < 60; i++)
            add_request(rand_angle(), rand_angle(), rand_angle());
        while (angle_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (basis_queue.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 4 * LATENCY)
        begin
            @(posedge clk);
            tail++;
        end

        $display("covered %0d angle triples incl. extremes, quadrant edges and wraparound",
                 n_sent);
        $display("checked %0d basis results under random stalls and a long output hold",
                 n_checked);
        if (n_errors == 0 && basis_queue.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
